// ===== rtl/dpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcs_pkg
// Shared types, constants and helpers for the depth control / plant step core.
// ----------------------------------------------------------------------------
package dpcs_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN        = 3'd0;
    localparam logic [2:0] CFG_TARGET      = 3'd1;
    localparam logic [2:0] CFG_BODY_MASS   = 3'd2;
    localparam logic [2:0] CFG_DRAG        = 3'd3;
    localparam logic [2:0] CFG_BUOYANCY    = 3'd4;
    localparam logic [2:0] CFG_TIME_STEP   = 3'd5;
    localparam logic [2:0] CFG_START_DEPTH = 3'd6;

    // Reset values, Q16.16
    localparam logic signed [31:0] RST_GAIN        = 32'sd0;
    localparam logic signed [31:0] RST_TARGET      = 32'sd655360;
    localparam logic        [30:0] RST_BODY_MASS   = 31'd655360;
    localparam logic signed [31:0] RST_DRAG        = 32'sd131072;
    localparam logic signed [31:0] RST_BUOYANCY    = -32'sd65536;
    localparam logic        [30:0] RST_TIME_STEP   = 31'd6554;
    localparam logic signed [31:0] RST_START_DEPTH = 32'sd1310720;

    // Divider: 48-bit magnitude quotient, two bits per cycle
    localparam int DIV_BITS      = 48;
    localparam int DIV_PER_CYCLE = 2;
    localparam int DIV_CYCLES    = DIV_BITS / DIV_PER_CYCLE;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_CTRL,
        ST_CTRL,
        ST_DRAG,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_ACCEL,
        ST_MUL_SPEED,
        ST_SPEED,
        ST_MUL_DEPTH,
        ST_DEPTH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_DIFF_GAIN,
        MUL_SPEED_DRAG,
        MUL_ACCEL_TS,
        MUL_SPEED_TS
    } mul_sel_t;

    typedef struct packed {
        logic     reload;
        logic     diff_en;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     ctrl_en;
        logic     drag_en;
        logic     sum_en;
        logic     div_init;
        logic     div_step;
        logic     accel_en;
        logic     speed_en;
        logic     depth_en;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    function automatic logic signed [31:0] sat_q(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > Q_MAX64) begin
            r = Q_MAX;
        end else if (x < Q_MIN64) begin
            r = Q_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sx32(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

// ===== rtl/dpcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpcs_ctrl
// Sequencer for one tick: walks the datapath through subtract, two multiplies,
// force sum, division, and the two Euler updates, then hands off the result.
// ----------------------------------------------------------------------------
module dpcs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_reload,
    output logic                s_ready,
    input  logic                out_free,
    output logic                out_load,
    output dpcs_pkg::dp_cmd_t   cmd,
    input  dpcs_pkg::dp_status_t status
);
    import dpcs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_reload ? ST_DONE : ST_DIFF;
                end
            end
            ST_DIFF:      state_next = ST_MUL_CTRL;
            ST_MUL_CTRL:  state_next = ST_CTRL;
            ST_CTRL:      state_next = ST_DRAG;
            ST_DRAG:      state_next = ST_SUM;
            ST_SUM:       state_next = ST_DIV_INIT;
            ST_DIV_INIT:  state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_ACCEL;
                end
            end
            ST_ACCEL:     state_next = ST_MUL_SPEED;
            ST_MUL_SPEED: state_next = ST_SPEED;
            ST_SPEED:     state_next = ST_MUL_DEPTH;
            ST_MUL_DEPTH: state_next = ST_DEPTH;
            ST_DEPTH:     state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.reload = s_valid && s_reload;
            end
            ST_DIFF:     cmd.diff_en = 1'b1;
            ST_MUL_CTRL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIFF_GAIN;
            end
            // control force reads the old product while the drag product loads
            ST_CTRL: begin
                cmd.ctrl_en = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SPEED_DRAG;
            end
            ST_DRAG:     cmd.drag_en  = 1'b1;
            ST_SUM:      cmd.sum_en   = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_ACCEL:    cmd.accel_en = 1'b1;
            ST_MUL_SPEED: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ACCEL_TS;
            end
            ST_SPEED:    cmd.speed_en = 1'b1;
            ST_MUL_DEPTH: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SPEED_TS;
            end
            ST_DEPTH:    cmd.depth_en = 1'b1;
            ST_DONE:     out_load = out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/dpcs_datapath.sv =====
// ----------------------------------------------------------------------------
// dpcs_datapath
// Configuration registers, plant state, one shared 32x32 signed multiplier,
// and a radix-4 restoring divider for the force / mass quotient.
// ----------------------------------------------------------------------------
module dpcs_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  dpcs_pkg::dp_cmd_t    cmd,
    output dpcs_pkg::dp_status_t status,
    output logic signed [31:0]   depth,
    output logic signed [31:0]   speed,
    output logic                 surfaced
);
    import dpcs_pkg::*;

    // configuration
    logic signed [31:0] gain_reg, target_reg, drag_reg_cfg, buoy_reg, start_reg;
    logic        [30:0] mass_reg, ts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= RST_GAIN;
            target_reg   <= RST_TARGET;
            mass_reg     <= RST_BODY_MASS;
            drag_reg_cfg <= RST_DRAG;
            buoy_reg     <= RST_BUOYANCY;
            ts_reg       <= RST_TIME_STEP;
            start_reg    <= RST_START_DEPTH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN:        gain_reg     <= cfg_wdata;
                CFG_TARGET:      target_reg   <= cfg_wdata;
                CFG_BODY_MASS:   mass_reg     <= cfg_wdata[30:0];
                CFG_DRAG:        drag_reg_cfg <= cfg_wdata;
                CFG_BUOYANCY:    buoy_reg     <= cfg_wdata;
                CFG_TIME_STEP:   ts_reg       <= cfg_wdata[30:0];
                CFG_START_DEPTH: start_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // plant state
    logic signed [31:0] speed_reg, depth_reg;
    logic               surf_reg;

    // intermediates
    logic signed [31:0] diff_reg, ctrl_reg, drag_reg, sum_reg, accel_reg, speed_new_reg;
    logic signed [63:0] prod_reg;

    logic signed [31:0] diff_next, ctrl_next, drag_next, sum_next, accel_next, speed_new_next;
    logic signed [31:0] depth_sat;
    logic signed [31:0] depth_next, speed_next;
    logic               surf_next;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    always_comb begin
        case (cmd.mul_sel)
            MUL_DIFF_GAIN: begin
                mul_a = diff_reg;
                mul_b = gain_reg;
            end
            MUL_SPEED_DRAG: begin
                mul_a = speed_reg;
                mul_b = drag_reg_cfg;
            end
            MUL_ACCEL_TS: begin
                mul_a = accel_reg;
                mul_b = {1'b0, ts_reg};
            end
            MUL_SPEED_TS: begin
                mul_a = speed_new_reg;
                mul_b = {1'b0, ts_reg};
            end
            default: begin
                mul_a = diff_reg;
                mul_b = gain_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // floor(prod / 2^16) as a 64-bit value
    logic signed [63:0] prod_q;
    logic signed [63:0] ctrl_scaled;
    logic signed [64:0] prod_neg;
    logic signed [63:0] drag_q;

    assign prod_q      = {{16{prod_reg[63]}}, prod_reg[63:16]};
    // -20 * x = -(16x + 4x); |x| < 2^47 so no overflow in 64 bits
    assign ctrl_scaled = 64'sd0 - ((prod_q <<< 4) + (prod_q <<< 2));
    assign prod_neg    = 65'sd0 - {prod_reg[63], prod_reg};
    assign drag_q      = {{15{prod_neg[64]}}, prod_neg[64:16]};

    assign diff_next      = sat_q(sx32(depth_reg) - sx32(target_reg));
    assign ctrl_next      = sat_q(ctrl_scaled);
    assign drag_next      = sat_q(drag_q);
    assign sum_next       = sat_q(sx32(buoy_reg) + sx32(drag_reg) + sx32(ctrl_reg));
    assign speed_new_next = sat_q(sx32(speed_reg) + prod_q);
    assign depth_sat      = sat_q(sx32(depth_reg) + prod_q);

    // divider: |sum| << 16 divided by mass, quotient replaces dividend bits
    logic [30:0]          rem_reg;
    logic [DIV_BITS-1:0]  dvd_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [30:0]          rem_next;
    logic [DIV_BITS-1:0]  dvd_next;
    logic [31:0]          sum_mag;

    assign sum_mag = sum_reg[31] ? (32'd0 - sum_reg) : sum_reg;

    always_comb begin
        logic [31:0]         trial;
        logic [30:0]         r;
        logic [DIV_BITS-1:0] d;
        r     = rem_reg;
        d     = dvd_reg;
        trial = '0;
        for (int i = 0; i < DIV_PER_CYCLE; i++) begin
            trial = {r, d[DIV_BITS-1]};
            d     = {d[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, mass_reg}) begin
                trial = trial - {1'b0, mass_reg};
                d[0]  = 1'b1;
            end
            r = trial[30:0];
        end
        rem_next = r;
        dvd_next = d;
    end

    assign status.div_done = (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));

    // signed, saturated acceleration; zero force gives zero even at zero mass
    always_comb begin
        if (sum_reg == 32'sd0) begin
            accel_next = 32'sd0;
        end else if (neg_reg) begin
            if (dvd_reg > DIV_BITS'(64'd2147483648)) begin
                accel_next = Q_MIN;
            end else begin
                accel_next = 32'sd0 - dvd_reg[31:0];
            end
        end else if (dvd_reg > DIV_BITS'(64'd2147483647)) begin
            accel_next = Q_MAX;
        end else begin
            accel_next = dvd_reg[31:0];
        end
    end

    // surface clamp
    always_comb begin
        if (depth_sat[31] || depth_sat == 32'sd0) begin
            depth_next = 32'sd0;
            speed_next = 32'sd0;
            surf_next  = 1'b1;
        end else begin
            depth_next = depth_sat;
            speed_next = speed_new_reg;
            surf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= 32'sd0;
            depth_reg <= RST_START_DEPTH;
            surf_reg  <= 1'b0;
        end else if (cmd.reload) begin
            speed_reg <= 32'sd0;
            depth_reg <= start_reg;
            surf_reg  <= 1'b0;
        end else if (cmd.depth_en) begin
            speed_reg <= speed_next;
            depth_reg <= depth_next;
            surf_reg  <= surf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff_en)  diff_reg      <= diff_next;
        if (cmd.mul_en)   prod_reg      <= mul_p;
        if (cmd.ctrl_en)  ctrl_reg      <= ctrl_next;
        if (cmd.drag_en)  drag_reg      <= drag_next;
        if (cmd.sum_en)   sum_reg       <= sum_next;
        if (cmd.accel_en) accel_reg     <= accel_next;
        if (cmd.speed_en) speed_new_reg <= speed_new_next;
        if (cmd.div_init) begin
            rem_reg <= '0;
            dvd_reg <= {sum_mag, 16'd0};
            neg_reg <= sum_reg[31];
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_init) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign depth    = depth_reg;
    assign speed    = speed_reg;
    assign surfaced = surf_reg;

endmodule

// ===== rtl/depth_p_control_plant_step_core.sv =====
// ----------------------------------------------------------------------------
// depth_p_control_plant_step_core
// One closed-loop tick of a proportional depth controller and vehicle plant.
// ----------------------------------------------------------------------------
// Requests: one at a time; a new request is accepted only after the previous
//   result has been loaded into the output register. A tick runs the shared
//   divider, retiring two quotient bits per cycle, and four passes of the one
//   multiplier; a reload loads the start depth and then hands off its result.
// Reset: synchronous active-low; configuration registers return to defaults, speed 0, depth
//   at the default start depth, no result pending.
module depth_p_control_plant_step_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_reload,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_depth_out,
    output logic signed [31:0] m_speed_out,
    output logic               m_surfaced
);
    import dpcs_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic               out_free;
    logic               out_load;
    logic signed [31:0] dp_depth, dp_speed;
    logic               dp_surf;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_depth_reg, m_speed_reg;
    logic               m_surf_reg;

    assign out_free = !m_valid_reg || m_ready;

    dpcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_reload (s_reload),
        .s_ready  (s_ready),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .status   (status)
    );

    dpcs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .depth     (dp_depth),
        .speed     (dp_speed),
        .surfaced  (dp_surf)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_depth_reg <= dp_depth;
            m_speed_reg <= dp_speed;
            m_surf_reg  <= dp_surf;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_depth_out = m_depth_reg;
    assign m_speed_out = m_speed_reg;
    assign m_surfaced  = m_surf_reg;

`ifndef SYNTHESIS
    // a surfaced result is clamped to rest at zero depth
    a_surface_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_surfaced |-> m_depth_out == 32'sd0 && m_speed_out == 32'sd0)
        else $error("surfaced result not clamped");

    // only one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // a surfaced result never carries a negative depth
    a_depth_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_surfaced |-> !m_depth_out[31])
        else $error("negative depth on surfaced result");
`endif

endmodule

// ===== sim/depth_p_control_plant_step_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_p_control_plant_step_core_tb
// Self-checking bench for the depth control / plant step core. A queue-fed
// driver offers reload and tick requests, and a monitor checks every result
// against an in-bench fixed-point model of the loop. Register settings change
// only while the core is idle. Both sides stall at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module depth_p_control_plant_step_core_tb;
    import dpcs_pkg::*;

    localparam logic [2:0] CFG_UNUSED   = 3'd7;
    localparam longint     QHI          = 64'sd2147483647;
    localparam longint     QLO          = -64'sd2147483648;
    localparam int         DRAIN_CYCLES = 48;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         RAND_PHASES  = 10;
    localparam int         PHASE_ITEMS  = 55;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [31:0] speed;
        logic               surfaced;
    } plant_out_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic               s_reload  = 1'b0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [31:0] m_depth_out;
    logic signed [31:0] m_speed_out;
    logic               m_surfaced;

    // loop model: settings and state
    longint k_gain, k_target, k_mass, k_drag, k_buoy, k_dt, k_start;
    longint plant_speed, plant_depth;

    bit         reload_pending_q[$];
    plant_out_t plant_expect_q[$];
    plant_out_t head;

    bit          s_taken  = 1'b0;
    bit          no_gaps  = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_rx  = 1'b0;
    int unsigned tx_gap   = 0;
    int unsigned rx_gap   = 0;
    int          n_errors = 0;
    int          n_accepted = 0;
    int          n_reloads  = 0;
    int          n_results  = 0;
    int          n_surfaced = 0;
    int          n_settings = 1;

    depth_p_control_plant_step_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_reload    (s_reload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_depth_out (m_depth_out),
        .m_speed_out (m_speed_out),
        .m_surfaced  (m_surfaced)
    );

    always #1 aclk = ~aclk;

    function automatic longint clamp32(input longint x);
        if (x > QHI) begin
            return QHI;
        end
        if (x < QLO) begin
            return QLO;
        end
        return x;
    endfunction

    // One request through the loop; >>> 16 is the floor of a Q16.16 product.
    function automatic plant_out_t advance_plant(input bit reload);
        longint     diff, control, drag, sum, accel, speed, depth;
        plant_out_t r;
        r.surfaced = 1'b0;
        if (reload) begin
            plant_depth = k_start;
            plant_speed = 0;
        end else begin
            diff    = clamp32(plant_depth - k_target);
            control = clamp32(-20 * ((diff * k_gain) >>> 16));
            drag    = clamp32((-plant_speed * k_drag) >>> 16);
            sum     = clamp32(k_buoy + drag + control);
            if (k_mass == 0) begin
                accel = (sum > 0) ? QHI : ((sum < 0) ? QLO : 0);
            end else begin
                accel = clamp32((sum * 65536) / k_mass);
            end
            speed = clamp32(plant_speed + ((accel * k_dt) >>> 16));
            depth = clamp32(plant_depth + ((speed * k_dt) >>> 16));
            if (depth <= 0) begin
                depth      = 0;
                speed      = 0;
                r.surfaced = 1'b1;
            end
            plant_speed = speed;
            plant_depth = depth;
        end
        r.depth = plant_depth[31:0];
        r.speed = plant_speed[31:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(40, 120);
    endfunction

    function automatic logic [31:0] pick_value(input int lo, input int hi, input bit wild);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (wild && r < 3) begin
            return 32'h8000_0000;
        end
        if (wild && r < 6) begin
            return 32'h7FFF_FFFF;
        end
        if (wild) begin
            return $urandom();
        end
        return 32'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_GAIN:        k_gain   = longint'($signed(val));
            CFG_TARGET:      k_target = longint'($signed(val));
            CFG_BODY_MASS:   k_mass   = longint'({1'b0, val[30:0]});
            CFG_DRAG:        k_drag   = longint'($signed(val));
            CFG_BUOYANCY:    k_buoy   = longint'($signed(val));
            CFG_TIME_STEP:   k_dt     = longint'({1'b0, val[30:0]});
            CFG_START_DEPTH: k_start  = longint'($signed(val));
            default: begin
            end
        endcase
    endtask

    // Sampled at posedge, where a popped request already shows on s_valid.
    task automatic wait_idle();
        while (reload_pending_q.size() != 0 || s_valid || plant_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (tx_gap > 0) begin
                s_valid <= 1'b0;
                tx_gap  <= tx_gap - 1;
            end else if (reload_pending_q.size() > 0) begin
                s_valid  <= 1'b1;
                s_reload <= reload_pending_q.pop_front();
                tx_gap   <= no_gaps ? 0 : draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn || hold_rx) begin
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) begin
                rx_gap <= draw_gap();
            end
        end
    end

    // long receiver hold-off while requests keep coming
    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    // monitor: results are checked before this edge's request is predicted
    always @(posedge aclk) begin
        s_taken = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (plant_expect_q.size() == 0) begin
                    $error("result with no request pending: depth %0d speed %0d",
                           m_depth_out, m_speed_out);
                    n_errors++;
                end else begin
                    head = plant_expect_q.pop_front();
                    n_results++;
                    if (m_surfaced) begin
                        n_surfaced++;
                    end
                    if (m_depth_out !== head.depth) begin
                        $error("depth_out: expected %0d, actual %0d", head.depth, m_depth_out);
                        n_errors++;
                    end
                    if (m_speed_out !== head.speed) begin
                        $error("speed_out: expected %0d, actual %0d", head.speed, m_speed_out);
                        n_errors++;
                    end
                    if (m_surfaced !== head.surfaced) begin
                        $error("surfaced: expected %0d, actual %0d", head.surfaced, m_surfaced);
                        n_errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                s_taken = 1'b1;
                n_accepted++;
                if (s_reload) begin
                    n_reloads++;
                end
                plant_expect_q.push_back(advance_plant(s_reload));
            end
        end
    end

    initial begin
        #1_500_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        bit all_wild;
        k_gain      = longint'(RST_GAIN);
        k_target    = longint'(RST_TARGET);
        k_mass      = longint'(RST_BODY_MASS);
        k_drag      = longint'(RST_DRAG);
        k_buoy      = longint'(RST_BUOYANCY);
        k_dt        = longint'(RST_TIME_STEP);
        k_start     = longint'(RST_START_DEPTH);
        plant_speed = 0;
        plant_depth = k_start;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults after reset
        reload_pending_q = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
        wait_idle();

        // ignored index; start depth write leaves depth alone until a reload,
        // and a reload to a negative depth is not clamped
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_START_DEPTH, 32'hFFFB_0000);
        reload_pending_q = '{1'b0, 1'b1, 1'b0};
        n_settings++;
        wait_idle();

        // zero mass with positive, negative and zero force sums
        write_reg(CFG_START_DEPTH, 32'h0014_0000);
        write_reg(CFG_BODY_MASS, 32'h8000_0000);
        write_reg(CFG_BUOYANCY, 32'h0001_0000);
        reload_pending_q = '{1'b1, 1'b0};
        n_settings++;
        wait_idle();
        write_reg(CFG_BUOYANCY, 32'h8000_0000);
        reload_pending_q = '{1'b1, 1'b0};
        n_settings++;
        wait_idle();
        write_reg(CFG_BUOYANCY, 32'h0000_0000);
        write_reg(CFG_DRAG, 32'h0000_0000);
        reload_pending_q = '{1'b1, 1'b0};
        n_settings++;
        wait_idle();

        // saturating extremes, both signs
        write_reg(CFG_GAIN, 32'h8000_0000);
        write_reg(CFG_TARGET, 32'h7FFF_FFFF);
        write_reg(CFG_BODY_MASS, 32'h0000_0001);
        write_reg(CFG_DRAG, 32'h8000_0000);
        write_reg(CFG_BUOYANCY, 32'h7FFF_FFFF);
        write_reg(CFG_TIME_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_START_DEPTH, 32'h7FFF_FFFF);
        reload_pending_q = '{1'b1, 1'b0, 1'b0};
        n_settings++;
        wait_idle();
        write_reg(CFG_GAIN, 32'h7FFF_FFFF);
        write_reg(CFG_TARGET, 32'h8000_0000);
        write_reg(CFG_BODY_MASS, 32'h7FFF_FFFF);
        write_reg(CFG_DRAG, 32'h7FFF_FFFF);
        write_reg(CFG_BUOYANCY, 32'h8000_0000);
        write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_START_DEPTH, 32'h8000_0000);
        reload_pending_q = '{1'b1, 1'b0, 1'b0};
        n_settings++;
        wait_idle();

        // random settings, each phase a reload followed by mostly ticks
        for (int p = 0; p < RAND_PHASES; p++) begin
            all_wild = (p % 4 == 1);
            no_gaps  = (p == 3);
            write_reg(CFG_GAIN,
                      pick_value(-262144, 262144, all_wild || $urandom_range(0, 6) == 0));
            write_reg(CFG_TARGET,
                      pick_value(0, 6553600, all_wild || $urandom_range(0, 6) == 0));
            write_reg(CFG_BODY_MASS,
                      pick_value(1, 3276800, all_wild || $urandom_range(0, 6) == 0));
            write_reg(CFG_DRAG,
                      pick_value(-262144, 524288, all_wild || $urandom_range(0, 6) == 0));
            write_reg(CFG_BUOYANCY,
                      pick_value(-1310720, 1310720, all_wild || $urandom_range(0, 6) == 0));
            write_reg(CFG_TIME_STEP,
                      pick_value(0, 65536, all_wild || $urandom_range(0, 6) == 0));
            write_reg(CFG_START_DEPTH,
                      pick_value(-655360, 13107200, all_wild || $urandom_range(0, 6) == 0));
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_UNUSED, $urandom());
            end
            n_settings++;
            reload_pending_q.push_back(1'b1);
            for (int i = 1; i < PHASE_ITEMS; i++)
                reload_pending_q.push_back($urandom_range(0, 99) < 6);
            if (p == 2) begin
                hold_req = 1'b1;
            end
            wait_idle();
        end
        no_gaps = 1'b0;

        $display("Ran %0d requests (%0d reloads) across %0d register settings.",
                 n_accepted, n_reloads, n_settings);
        $display("Checked %0d results, %0d of them surfaced; errors: %0d.",
                 n_results, n_surfaced, n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
